// ===== rtl/core/start_byte_idle_timeout_deframer_assert.svh =====
// Assertion macros for the start-byte deframer.
// Included by the top level; empty bodies when SYNTHESIS is defined.
`ifndef START_BYTE_IDLE_TIMEOUT_DEFRAMER_ASSERT_SVH
`define START_BYTE_IDLE_TIMEOUT_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define SBITD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SBITD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SBITD_ASSERT_IMPL(lbl, ante, cons, msg)
`define SBITD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/sbitd_pkg.sv =====
// Shared types and constants for the start-byte deframer.
// No dependencies.
`default_nettype none
package sbitd_pkg;
  localparam int FRAME_MAX_LEN_DEF = 32;
  localparam int DATA_W = 8;
  localparam int IDX_W = 6;
  localparam int LEN_W = 7;
  localparam int IDLE_W = 9;
  localparam int TDATA_OUT_W = 24;
  localparam int PAD_W = TDATA_OUT_W - DATA_W - IDX_W - LEN_W;

  localparam logic [DATA_W-1:0] START_BYTE = 8'h01;
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 7'd3;
  localparam logic [DATA_W-1:0] TIMEOUT_RESET = 8'd20;
  localparam logic [IDLE_W-1:0] IDLE_MAX = 9'd511;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic bank;
    logic [LEN_W-1:0] len;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/core/sbitd_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none
module sbitd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sbitd_front.sv =====
// Front end: takes bytes and ticks, stores frame bytes, closes frames into jobs.
// Depends on sbitd_pkg.
`default_nettype none
module sbitd_front #(
  parameter int FRAME_MAX_LEN = sbitd_pkg::FRAME_MAX_LEN_DEF,
  localparam int IW = $clog2(FRAME_MAX_LEN),
  localparam int AW = IW + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sbitd_pkg::DATA_W-1:0]  cfg_wr_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [sbitd_pkg::DATA_W-1:0]  s_tdata,
  input  wire logic                          s_tuser,
  input  wire logic                          q_full,
  output logic                               q_push,
  output sbitd_pkg::job_t                    q_job,
  output logic                               mem_wr_en,
  output logic [AW-1:0]                      mem_wr_addr,
  output logic [sbitd_pkg::DATA_W-1:0]       mem_wr_data
);
  import sbitd_pkg::*;

  logic [DATA_W-1:0] timeout;
  logic              collecting, collecting_next;
  logic [LEN_W-1:0]  fill, fill_next;
  logic [IDLE_W-1:0] idle, idle_next;
  logic              wr_bank, wr_bank_next;
  logic [LEN_W-1:0]  wr_idx;
  logic [IDLE_W-1:0] idle_inc;
  logic              acc;

  assign s_tready = !q_full;
  assign acc = s_tvalid && s_tready;
  assign wr_idx = (fill >= LEN_W'(FRAME_MAX_LEN)) ? '0 : fill;
  assign idle_inc = (idle == IDLE_MAX) ? idle : idle + 1'b1;
  assign mem_wr_addr = {wr_bank, wr_idx[IW-1:0]};
  assign mem_wr_data = s_tdata;
  assign q_job.bank = wr_bank;
  assign q_job.len = fill;

  always_comb begin
    collecting_next = collecting;
    fill_next = fill;
    idle_next = idle;
    wr_bank_next = wr_bank;
    mem_wr_en = 1'b0;
    q_push = 1'b0;
    if (acc) begin
      if (s_tuser == OP_BYTE) begin
        if (collecting || s_tdata == START_BYTE) begin
          mem_wr_en = 1'b1;
          fill_next = wr_idx + 1'b1;
          collecting_next = 1'b1;
          idle_next = '0;
        end
      end else if (collecting) begin
        if (idle_inc > {1'b0, timeout}) begin
          collecting_next = 1'b0;
          fill_next = '0;
          idle_next = '0;
          if (fill >= MIN_FRAME_LEN) begin
            q_push = 1'b1;
            wr_bank_next = ~wr_bank;
          end
        end else begin
          idle_next = idle_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
      collecting <= 1'b0;
      fill <= '0;
      idle <= '0;
      wr_bank <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      collecting <= collecting_next;
      fill <= fill_next;
      idle <= idle_next;
      wr_bank <= wr_bank_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sbitd_queue.sv =====
// Two-entry job queue between front and back; one entry per buffer bank.
// Depends on sbitd_pkg.
`default_nettype none
module sbitd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sbitd_pkg::job_t push_job,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output sbitd_pkg::job_t      head_job
);
  import sbitd_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sbitd_back.sv =====
// Back end: drains a queued frame from its bank, one word per cycle while m_tready does not stall it.
// Depends on sbitd_pkg.
`default_nettype none
module sbitd_back #(
  parameter int FRAME_MAX_LEN = sbitd_pkg::FRAME_MAX_LEN_DEF,
  localparam int IW = $clog2(FRAME_MAX_LEN),
  localparam int AW = IW + 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                head_valid,
  input  wire sbitd_pkg::job_t                     head_job,
  output logic                                     pop,
  output logic                                     mem_rd_en,
  output logic [AW-1:0]                            mem_rd_addr,
  input  wire logic [sbitd_pkg::DATA_W-1:0]        mem_rd_data,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [sbitd_pkg::TDATA_OUT_W-1:0]        m_tdata,
  output logic                                     m_tlast
);
  import sbitd_pkg::*;

  logic [LEN_W-1:0]  rd_idx;
  logic              rd_last;
  logic              s1_vld;
  logic [IDX_W-1:0]  s1_idx;
  logic [LEN_W-1:0]  s1_len;
  logic              s1_last;
  logic              out_load;
  logic [DATA_W-1:0] o_byte;
  logic [IDX_W-1:0]  o_idx;
  logic [LEN_W-1:0]  o_len;

  assign out_load = s1_vld && (!m_tvalid || m_tready);
  assign mem_rd_en = head_valid && (!s1_vld || out_load);
  assign mem_rd_addr = {head_job.bank, rd_idx[IW-1:0]};
  assign rd_last = (rd_idx + 1'b1 == head_job.len);
  assign pop = mem_rd_en && rd_last;
  assign m_tdata = {{PAD_W{1'b0}}, o_len, o_idx, o_byte};

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      s1_idx <= rd_idx[IDX_W-1:0];
      s1_len <= head_job.len;
      s1_last <= rd_last;
    end
    if (out_load) begin
      o_byte <= mem_rd_data;
      o_idx <= s1_idx;
      o_len <= s1_len;
      m_tlast <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      s1_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (mem_rd_en) begin
        rd_idx <= rd_last ? '0 : rd_idx + 1'b1;
        s1_vld <= 1'b1;
      end else if (out_load) begin
        s1_vld <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/start_byte_idle_timeout_deframer.sv =====
// Top level of the start-byte / idle-gap deframer.
// Depends on sbitd_pkg, sbitd_ram, sbitd_front, sbitd_queue, sbitd_back.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: data_byte; tuser: operation
//  m_*      out  m_tvalid/m_tready  tdata: frame_byte, byte_index, frame_length; tlast
//  cfg_*    in   cfg_wr_en          idle_timeout_ticks
//
// One input word is taken per cycle while a buffer bank is free.
// A closed frame drains one word per cycle while m_tready does not stall it.
// Two banks of FRAME_MAX_LEN bytes: input stalls only while both hold frames.
// Synchronous reset; no clearing pass is needed.
`default_nettype none
`include "start_byte_idle_timeout_deframer_assert.svh"
module start_byte_idle_timeout_deframer #(
  parameter int FRAME_MAX_LEN = sbitd_pkg::FRAME_MAX_LEN_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [sbitd_pkg::DATA_W-1:0]       cfg_wr_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [sbitd_pkg::DATA_W-1:0]       s_tdata,  // [7:0] data_byte
  input  wire logic                               s_tuser,  // [0] operation
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [7:0] frame_byte, [13:8] byte_index, [20:14] frame_length, [23:21] zero
  output logic [sbitd_pkg::TDATA_OUT_W-1:0]       m_tdata,
  output logic                                    m_tlast
);
  import sbitd_pkg::*;

  localparam int IW = $clog2(FRAME_MAX_LEN);
  localparam int AW = IW + 1;

  logic              q_full;
  logic              q_push;
  job_t              q_job;
  logic              q_pop;
  logic              head_valid;
  job_t              head_job;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [DATA_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;

  sbitd_front #(.FRAME_MAX_LEN(FRAME_MAX_LEN)) u_front (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_full(q_full), .q_push(q_push), .q_job(q_job),
    .mem_wr_en(mem_wr_en), .mem_wr_addr(mem_wr_addr), .mem_wr_data(mem_wr_data)
  );

  sbitd_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_job(q_job), .pop(q_pop),
    .full(q_full), .head_valid(head_valid), .head_job(head_job)
  );

  sbitd_ram #(.WIDTH(DATA_W), .DEPTH(2 ** AW)) u_ram (
    .clk(clk),
    .wr_en(mem_wr_en), .wr_addr(mem_wr_addr), .wr_data(mem_wr_data),
    .rd_en(mem_rd_en), .rd_addr(mem_rd_addr), .rd_data(mem_rd_data)
  );

  sbitd_back #(.FRAME_MAX_LEN(FRAME_MAX_LEN)) u_back (
    .clk(clk), .rst(rst),
    .head_valid(head_valid), .head_job(head_job), .pop(q_pop),
    .mem_rd_en(mem_rd_en), .mem_rd_addr(mem_rd_addr), .mem_rd_data(mem_rd_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  `SBITD_ASSERT_IMPL(a_push_not_full, q_push, !q_full, "job pushed into full queue")
  `SBITD_ASSERT_IMPL(a_job_len, q_push, q_job.len >= MIN_FRAME_LEN, "short frame queued")
  `SBITD_ASSERT_IMPL(a_last_idx, m_tvalid && m_tlast, m_tdata[13:8] + 7'd1 == m_tdata[20:14], "last word index mismatch")
  `SBITD_ASSERT_NEXT(a_pop_frees, q_pop && !q_push, !q_full, "queue still full after pop")
endmodule
`default_nettype wire
